/* rtl/crf_pkg.sv */
// shared types and constants for the coordinate ring fifo
// used by crf_ctrl, crf_dp and coordinate_ring_fifo; depends on nothing else
package crf_pkg;

  // item kinds carried on the slave-side tuser
  typedef enum logic [1:0] {
    KIND_PUSH        = 2'd0,
    KIND_POP         = 2'd1,
    KIND_READ_AT     = 2'd2,
    KIND_READ_NEWEST = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  // controller states
  typedef enum logic {
    CS_IDLE   = 1'b0,
    CS_FINISH = 1'b1
  } ctrl_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic start;     // item accepted: update pointers, issue slot read, stage result
    logic load_out;  // move the staged result into the output register
  } cmd_t;

  // pair returned by an out-of-range read
  localparam logic signed [15:0] SENTINEL = 16'sd1000;

  // packed widths of the stream payloads
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned COUNT_W    = 6;

endpackage

/* rtl/crf_ctrl.sv */
// controller state machine for the coordinate ring fifo
// sequences accept, result staging and output hand-off; uses crf_pkg
module crf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output crf_pkg::cmd_t cmd
);
  import crf_pkg::*;

  ctrl_state_t state, state_next;
  logic        out_valid_next;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CS_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd.start      = 1'b0;
    cmd.load_out   = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = CS_FINISH;
        end
      end
      CS_FINISH: begin
        // staged result waits here until the output register is free
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = CS_IDLE;
        end
      end
      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

endmodule

/* rtl/crf_dp.sv */
// datapath for the coordinate ring fifo: slot memory, pointers, count,
// result staging and output register; uses crf_pkg, driven by crf_ctrl
module crf_dp #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  crf_pkg::cmd_t                    cmd,
  input  logic [crf_pkg::KIND_W-1:0]       in_kind,
  input  logic signed [15:0]               in_x,
  input  logic signed [15:0]               in_y,
  input  logic [crf_pkg::POS_W-1:0]        in_pos,
  output logic signed [15:0]               out_x,
  output logic signed [15:0]               out_y,
  output logic [1:0]                       out_status,
  output logic [crf_pkg::COUNT_W-1:0]      out_count
);
  import crf_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned NW = (AW > POS_W) ? AW : POS_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_W   = (AW + 1)'(DEPTH);

  // slot memory: x in the low half, y in the high half
  logic [31:0] mem [DEPTH];
  logic [31:0] rdata;

  logic [AW-1:0] wr_ptr, rd_ptr, cnt;
  logic [AW-1:0] wr_ptr_next, rd_ptr_next, cnt_next;

  // staged result of the item in flight
  status_t              st_status;
  logic [COUNT_W-1:0]   st_count;
  logic                 st_is_read;

  kind_t         kind;
  status_t       status_next;
  logic          is_read, in_range, wr_en, rd_en;
  logic [NW-1:0] n_sel;
  logic [AW:0]   idx_sum;
  logic [AW-1:0] rd_idx;
  logic [AW+COUNT_W-1:0] cnt_ext;

  assign kind = kind_t'(in_kind);

  // per-kind pointer, count and status update
  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    cnt_next    = cnt;
    status_next = STAT_OK;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    is_read     = 1'b0;
    n_sel       = (kind == KIND_READ_AT) ? NW'(in_pos) : NW'(cnt);
    in_range    = (n_sel != '0) && (n_sel <= NW'(cnt));
    // slot of the n-th oldest entry, wrapped once
    idx_sum     = {1'b0, rd_ptr} + (AW + 1)'(n_sel - NW'(1));
    rd_idx      = (idx_sum >= DEPTH_W) ? AW'(idx_sum - DEPTH_W) : idx_sum[AW-1:0];
    case (kind)
      KIND_PUSH: begin
        if (cnt == LAST_SLOT) begin
          status_next = STAT_FULL;
        end else begin
          wr_en       = 1'b1;
          wr_ptr_next = (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + AW'(1);
          cnt_next    = cnt + AW'(1);
        end
      end
      KIND_POP: begin
        if (cnt == '0) begin
          status_next = STAT_EMPTY;
        end else begin
          rd_ptr_next = (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + AW'(1);
          cnt_next    = cnt - AW'(1);
        end
      end
      default: begin
        is_read = 1'b1;
        if (in_range) begin
          rd_en = 1'b1;
        end else begin
          status_next = STAT_RANGE;
        end
      end
    endcase
  end

  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_next};

  // pointer and count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else if (cmd.start) begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      cnt    <= cnt_next;
    end
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (cmd.start && wr_en) begin
      mem[wr_ptr] <= {in_y, in_x};
    end
  end

  // memory read port, registered
  always_ff @(posedge clk) begin
    if (cmd.start && rd_en) begin
      rdata <= mem[rd_idx];
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      st_status  <= status_next;
      st_count   <= cnt_ext[COUNT_W-1:0];
      st_is_read <= is_read;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= st_status;
      out_count  <= st_count;
      if (st_is_read && st_status == STAT_OK) begin
        out_x <= rdata[15:0];
        out_y <= rdata[31:16];
      end else if (st_status == STAT_RANGE) begin
        out_x <= SENTINEL;
        out_y <= SENTINEL;
      end else begin
        out_x <= '0;
        out_y <= '0;
      end
    end
  end

endmodule

/* rtl/coordinate_ring_fifo.sv */
// top level of the coordinate ring fifo: stream ports, controller and datapath
// depends on crf_pkg, crf_ctrl and crf_dp
//
// A ring of DEPTH slots holding signed 16-bit (x,y) pairs, DEPTH-1 of them
// usable. Each beat in carries a kind on s_axis_tuser: push, pop oldest, read
// at a one-based position from the oldest, or read newest; each gives exactly
// one beat out with the pair read (zero for push and pop, 1000 for a read out
// of range), a status and the entry count after the item, masked to 6 bits.
// An accepted item has its slot read and its result staged in registers, and
// the staged result then enters the output register, so the block takes no
// new item until that is done; the slot memory has a registered read port.
// s_axis_tready is low in the cycle after each accept, and stays low while a
// finished result waits for a full output register to drain.
// The slot memory is not cleared after reset: it needs no clearing pass, as
// only written slots are ever read.
module coordinate_ring_fifo #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // coord_x [15:0], coord_y [31:16], position [38:32], zero [39]
  input  logic [crf_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // kind [1:0]
  input  logic [crf_pkg::KIND_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // out_x [15:0], out_y [31:16], status [33:32], count [39:34]
  output logic [crf_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
  import crf_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW+COUNT_W-1:0] FULL_EXT = (AW + COUNT_W)'(DEPTH - 1);
  localparam logic [COUNT_W-1:0]    FULL_CNT = FULL_EXT[COUNT_W-1:0];

  cmd_t               cmd;
  logic signed [15:0] out_x, out_y;
  logic [1:0]         out_status;
  logic [COUNT_W-1:0] out_count;

  // control
  crf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  // datapath
  crf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_kind    (s_axis_tuser),
    .in_x       (s_axis_tdata[15:0]),
    .in_y       (s_axis_tdata[31:16]),
    .in_pos     (s_axis_tdata[38:32]),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_status (out_status),
    .out_count  (out_count)
  );

  assign m_axis_tdata = {out_count, out_status, out_y, out_x};

  // one item at a time: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while the previous one was in flight");

  // a dropped push is only reported with the ring full
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[33:32] == STAT_FULL |->
      m_axis_tdata[39:34] == FULL_CNT)
    else $error("full status with a count below capacity");

  // out-of-range reads carry the sentinel pair
  a_range_sentinel: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[33:32] == STAT_RANGE |->
      m_axis_tdata[15:0] == SENTINEL && m_axis_tdata[31:16] == SENTINEL)
    else $error("out-of-range read without the sentinel pair");

  // an empty pop reports a zero count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[33:32] == STAT_EMPTY |->
      m_axis_tdata[39:34] == '0)
    else $error("empty status with a nonzero count");

endmodule
